@@ src/tce_pkg.sv @@
`default_nettype none

package tce_pkg;

  // field widths of the item and result beats
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int COORD_W = 8;
  localparam int IDX_W   = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUT        = 2'd0,
    OP_CLEAR      = 2'd1,
    OP_SET_CURSOR = 2'd2,
    OP_READ       = 2'd3
  } op_e;

  // control characters
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

  // cell words
  localparam logic [CHAR_W-1:0] TEXT_ATTR   = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0700;
  localparam logic [CELL_W-1:0] SCROLL_CELL = 16'h0020;

endpackage

`default_nettype wire

@@ src/tce_cell_ram.sv @@
`default_nettype none

module tce_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/text_console_engine_core.sv @@
`default_nettype none

// Text console over a COLUMNS x ROWS cell memory (attribute in the high byte, character in
// the low byte) with a cursor. Each input beat carries one operation and yields exactly one
// output beat holding the linear cursor position and, for a read of an index inside the memory,
// the cell word (zero otherwise). Printable bytes, control characters, cursor moves and cell
// reads are accepted in the idle state, which updates the memory or issues the read, and the
// result register is loaded in the finishing state once it is free. A clear sweeps the memory
// at one cell per cycle. A scroll copies the kept rows at one cell per cycle through the
// registered read port and then fills the freed rows. The single write port of the cell memory
// sets both rates. After reset a clearing pass writes every cell (COLUMNS*ROWS cells, 2000 at
// the default size) before the first item is taken. The next item may be accepted while the
// previous result still waits in the output register.
module text_console_engine_core
  import tce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [OP_W-1:0]    operation_i,
  input  wire logic [CHAR_W-1:0]  character_i,
  input  wire logic [COORD_W-1:0] column_i,
  input  wire logic [COORD_W-1:0] row_i,
  input  wire logic [IDX_W-1:0]   cell_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [POS_W-1:0]        cursor_position_o,
  output logic [CELL_W-1:0]       cell_data_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int NW    = RW + 1;
  localparam int LW    = (AW > POS_W) ? AW : POS_W;
  localparam int CMPW  = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_COPY,
    S_FILL,
    S_FINISH
  } state_e;

  state_e              state_q, state_d;
  logic [CLW-1:0]      col_q, col_d;
  logic [RW-1:0]       row_q, row_d;
  logic [AW-1:0]       dst_q, dst_d;
  logic [CW-1:0]       src_q, src_d;
  logic                cp_vld_q, cp_vld_d;
  logic [CELL_W-1:0]   fill_q, fill_d;
  logic                rdsel_q, rdsel_d;
  logic                out_valid_q, out_valid_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [CELL_W-1:0]   data_q, data_d;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [CELL_W-1:0]   ram_wdata, ram_rdata;

  logic [AW-1:0]       cur_lin;
  logic [LW-1:0]       pos_wide;
  logic [CMPW-1:0]     idx_ext;
  logic                idx_ok;
  logic [CLW-1:0]      tgt_col;
  logic [COORD_W-1:0]  tgt_row;
  logic                put_cell;
  logic [COORD_W-1:0]  excess;
  logic [NW-1:0]       scroll_n;
  logic [CW-1:0]       scroll_off;
  logic                accept;

  // cell memory
  tce_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (CELL_W)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // linear addresses of the cursor and of a read request
  assign cur_lin  = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign pos_wide = LW'(row_q) * LW'(COLUMNS) + LW'(col_q);
  assign idx_ext  = CMPW'(cell_index_i);
  assign idx_ok   = idx_ext < CMPW'(CELLS);

  assign accept = in_valid_i && (state_q == S_IDLE);

  // target cursor of the incoming item, before scrolling
  always_comb begin
    tgt_col  = col_q;
    tgt_row  = COORD_W'(row_q);
    put_cell = 1'b0;
    unique case (op_e'(operation_i))
      OP_PUT: begin
        unique case (character_i)
          CH_NEWLINE: begin
            tgt_col = '0;
            tgt_row = COORD_W'(row_q) + COORD_W'(1);
          end
          CH_BACKSPACE: begin
            if (col_q != '0) begin
              tgt_col = col_q - CLW'(1);
            end
          end
          CH_RETURN: begin
            tgt_col = '0;
          end
          default: begin
            put_cell = 1'b1;
            if (col_q == CLW'(COLUMNS - 1)) begin
              tgt_col = '0;
              tgt_row = COORD_W'(row_q) + COORD_W'(1);
            end else begin
              tgt_col = col_q + CLW'(1);
            end
          end
        endcase
      end
      OP_SET_CURSOR: begin
        if (column_i > COORD_W'(COLUMNS - 1)) begin
          tgt_col = CLW'(COLUMNS - 1);
        end else begin
          tgt_col = column_i[CLW-1:0];
        end
        tgt_row = row_i;
      end
      default: begin
      end
    endcase
  end

  // rows to scroll, capped at a full screen, and the copy source offset
  always_comb begin
    excess = tgt_row - COORD_W'(ROWS - 1);
    if (excess > COORD_W'(ROWS)) begin
      scroll_n = NW'(ROWS);
    end else begin
      scroll_n = excess[NW-1:0];
    end
    scroll_off = CW'(scroll_n) * CW'(COLUMNS);
  end

  // sequencer next state and memory ports
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    dst_d       = dst_q;
    src_d       = src_q;
    cp_vld_d    = cp_vld_q;
    fill_d      = fill_q;
    rdsel_d     = rdsel_q;
    out_valid_d = out_valid_q;
    pos_d       = pos_q;
    data_d      = data_q;
    ram_we      = 1'b0;
    ram_waddr   = dst_q;
    ram_wdata   = fill_q;
    ram_re      = 1'b0;
    ram_raddr   = src_q[AW-1:0];

    // output beat taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = BLANK_CELL;
        if (dst_q == AW'(CELLS - 1)) begin
          dst_d   = '0;
          state_d = S_IDLE;
        end else begin
          dst_d = dst_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          rdsel_d = 1'b0;
          if (op_e'(operation_i) == OP_CLEAR) begin
            col_d   = '0;
            row_d   = '0;
            dst_d   = '0;
            fill_d  = BLANK_CELL;
            state_d = S_FILL;
          end else begin
            // printable byte goes to the cell under the cursor
            if (put_cell) begin
              ram_we    = 1'b1;
              ram_waddr = cur_lin;
              ram_wdata = {TEXT_ATTR, character_i};
            end
            if (op_e'(operation_i) == OP_READ) begin
              ram_re    = 1'b1;
              ram_raddr = idx_ext[AW-1:0];
              rdsel_d   = idx_ok;
            end
            col_d = tgt_col;
            if (tgt_row >= COORD_W'(ROWS)) begin
              row_d    = RW'(ROWS - 1);
              src_d    = scroll_off;
              dst_d    = '0;
              cp_vld_d = 1'b0;
              fill_d   = SCROLL_CELL;
              state_d  = S_COPY;
            end else begin
              row_d   = tgt_row[RW-1:0];
              state_d = S_FINISH;
            end
          end
        end
      end

      S_COPY: begin
        // write back the cell read in the previous cycle, read the next one
        if (cp_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = dst_q;
          ram_wdata = ram_rdata;
          dst_d     = dst_q + AW'(1);
        end
        if (src_q < CW'(CELLS)) begin
          ram_re   = 1'b1;
          src_d    = src_q + CW'(1);
          cp_vld_d = 1'b1;
        end else begin
          cp_vld_d = 1'b0;
          if (!cp_vld_q) begin
            state_d = S_FILL;
          end
        end
      end

      S_FILL: begin
        ram_we = 1'b1;
        if (dst_q == AW'(CELLS - 1)) begin
          dst_d   = '0;
          state_d = S_FINISH;
        end else begin
          dst_d = dst_q + AW'(1);
        end
      end

      S_FINISH: begin
        // load the result once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          pos_d       = pos_wide[POS_W-1:0];
          data_d      = rdsel_q ? ram_rdata : '0;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state, cursor, sweep counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      col_q       <= '0;
      row_q       <= '0;
      dst_q       <= '0;
      src_q       <= '0;
      cp_vld_q    <= 1'b0;
      fill_q      <= BLANK_CELL;
      rdsel_q     <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      data_q      <= '0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      dst_q       <= dst_d;
      src_q       <= src_d;
      cp_vld_q    <= cp_vld_d;
      fill_q      <= fill_d;
      rdsel_q     <= rdsel_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      data_q      <= data_d;
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign cursor_position_o = pos_q;
  assign cell_data_o       = data_q;

  // cursor stays on screen between items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (row_q <= RW'(ROWS - 1)) && (col_q <= CLW'(COLUMNS - 1)))
    else $error("cursor off screen while idle");

  // scroll copy never overwrites a row still to be read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY && ram_we && ram_re) |-> (CW'(ram_waddr) < src_q))
    else $error("scroll copy write overtakes read");

  // an accepted item always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted item not started");

  // a result appears only from the finishing step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FINISH))
    else $error("result beat without finished item");

endmodule

`default_nettype wire
